### sv/sha512_pkg.sv
// SHA-512 stream hasher package: shared types, round constants, initial hash, rotate helper.
// No dependencies.
package sha512_pkg;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MERGE, ST_RUN, ST_FOLD, ST_LENBLK, ST_EMIT
   } state_type;

   function automatic logic [63:0] round_k(input logic [6:0] i);
      logic [63:0] k [0:79];
      k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      if (i < 7'd80) return k[i];
      return 64'h0;
   endfunction

   function automatic logic [63:0] init_hash(input logic [2:0] i);
      case (i)
         3'd0: return 64'h6a09e667f3bcc908;
         3'd1: return 64'hbb67ae8584caa73b;
         3'd2: return 64'h3c6ef372fe94f82b;
         3'd3: return 64'ha54ff53a5f1d36f1;
         3'd4: return 64'h510e527fade682d1;
         3'd5: return 64'h9b05688c2b3e6c1f;
         3'd6: return 64'h1f83d9abfb41bd6b;
         default: return 64'h5be0cd19137e2179;
      endcase
   endfunction

   function automatic logic [63:0] ror(input logic [63:0] v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

endpackage

### sv/sha512_queue.sv
// Two-entry queue between the accepting front and the hashing back end.
// Depends on sha512_pkg.
module sha512_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  sha512_pkg::item_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output sha512_pkg::item_type pop_data
);
   import sha512_pkg::*;

   item_type  slot_ff [2];
   logic      wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) slot_ff[wptr_ff] <= push_data;
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push_valid && push_ready) wptr_ff <= ~wptr_ff;
         if (pop_valid && pop_ready)   rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, push_valid && push_ready}
                     - {1'b0, pop_valid && pop_ready};
      end
   end
endmodule

### sv/sha512_core.sv
// SHA-512 back end: packs words into the block, pads, runs 80 rounds, emits digest.
// Depends on sha512_pkg.
module sha512_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sha512_pkg::item_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [63:0]          out_word,
   output logic [2:0]           out_index,
   output logic                 out_last
);
   import sha512_pkg::*;

   state_type    state_ff, state_in;
   logic [63:0]  h_ff [8];
   logic [63:0]  h_in [8];
   logic [63:0]  v_ff [8];
   logic [63:0]  v_in [8];
   logic [63:0]  w_ff [16];     // block words, then message schedule window
   logic [63:0]  w_in [16];
   logic [127:0] acc_ff, acc_in;     // pending bytes, left aligned
   logic [4:0]   accn_ff, accn_in;   // bytes in acc (0..15)
   logic [3:0]   widx_ff, widx_in;   // next block word
   logic [63:0]  bits_ff, bits_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         pend_last_ff, pend_last_in;  // padding still to do
   logic         need_len_ff, need_len_in;    // length goes in a block of its own
   logic         final_ff, final_in;          // this compression is the final one
   logic [2:0]   oidx_ff, oidx_in;

   logic [3:0]   nb;
   logic [63:0]  t1, t2, wnew, s0, s1, a, e;
   logic [127:0] acc_add, pad_acc;

   assign nb = (in_data.nbytes > 4'd8) ? 4'd8 : in_data.nbytes;
   assign acc_add = {in_data.word & ~(64'hffffffffffffffff >> {nb, 3'b000}), 64'h0};
   assign pad_acc = acc_ff | ({8'h80, 120'h0} >> {accn_ff, 3'b000});
   assign a  = v_ff[0];
   assign e  = v_ff[4];
   assign s0 = ror(w_ff[1], 1) ^ ror(w_ff[1], 8) ^ (w_ff[1] >> 7);
   assign s1 = ror(w_ff[14], 19) ^ ror(w_ff[14], 61) ^ (w_ff[14] >> 6);
   assign wnew = w_ff[0] + s0 + w_ff[9] + s1;
   assign t1 = v_ff[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
               + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
   assign t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
               + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_EMIT);
   assign out_word  = h_ff[oidx_ff];
   assign out_index = oidx_ff;
   assign out_last  = (oidx_ff == 3'd7);

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      accn_in      = accn_ff;
      widx_in      = widx_ff;
      bits_in      = bits_ff;
      rnd_in       = rnd_ff;
      pend_last_in = pend_last_ff;
      need_len_in  = need_len_ff;
      final_in     = final_ff;
      oidx_in      = oidx_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) begin
            // append bytes behind the pending ones
            acc_in       = acc_ff | (acc_add >> {accn_ff, 3'b000});
            accn_in      = accn_ff + {1'b0, nb};
            bits_in      = bits_ff + {57'd0, nb, 3'b000};
            pend_last_in = in_data.last;
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            if (accn_ff >= 5'd8) begin
               w_in[widx_ff] = acc_ff[127:64];
               acc_in  = {acc_ff[63:0], 64'h0};
               accn_in = accn_ff - 5'd8;
               widx_in = widx_ff + 4'd1;
               if (widx_ff == 4'd15) begin
                  v_in     = h_ff;
                  rnd_in   = 7'd0;
                  final_in = 1'b0;
                  state_in = ST_RUN;
               end else if (!pend_last_ff) state_in = ST_IDLE;
            end else if (pend_last_ff) begin
               // tail bytes, 0x80, zeros, then the length if it fits
               w_in[widx_ff] = pad_acc[127:64];
               pend_last_in = 1'b0;
               acc_in   = 128'h0;
               accn_in  = 5'd0;
               widx_in  = 4'd0;
               v_in     = h_ff;
               rnd_in   = 7'd0;
               state_in = ST_RUN;
               if (widx_ff <= 4'd13) begin
                  for (int i = 0; i < 15; i++)
                     if (4'(i) > widx_ff) w_in[i] = 64'h0;
                  w_in[15] = bits_ff;
                  final_in = 1'b1;
               end else begin
                  if (widx_ff == 4'd14) w_in[15] = 64'h0;
                  final_in    = 1'b0;
                  need_len_in = 1'b1;
               end
            end else state_in = ST_IDLE;
         end
         ST_RUN: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = wnew;
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            rnd_in = 7'd0;
            if (final_ff) begin
               oidx_in  = 3'd0;
               state_in = ST_EMIT;
            end else if (need_len_ff) state_in = ST_LENBLK;
            else if (pend_last_ff)    state_in = ST_MERGE;
            else                      state_in = ST_IDLE;
         end
         ST_LENBLK: begin
            // extra block: zeros and the length
            for (int i = 0; i < 15; i++) w_in[i] = 64'h0;
            w_in[15]    = bits_ff;
            v_in        = h_ff;
            rnd_in      = 7'd0;
            final_in    = 1'b1;
            need_len_in = 1'b0;
            state_in    = ST_RUN;
         end
         ST_EMIT: if (out_ready) begin
            oidx_in = oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) h_in[i] = init_hash(3'(i));
               bits_in  = 64'd0;
               final_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
         acc_ff <= 128'h0; accn_ff <= 5'd0; widx_ff <= 4'd0; bits_ff <= 64'd0;
         rnd_ff <= 7'd0; pend_last_ff <= 1'b0; need_len_ff <= 1'b0;
         final_ff <= 1'b0; oidx_ff <= 3'd0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         acc_ff       <= acc_in;
         accn_ff      <= accn_in;
         widx_ff      <= widx_in;
         bits_ff      <= bits_in;
         rnd_ff       <= rnd_in;
         pend_last_ff <= pend_last_in;
         need_len_ff  <= need_len_in;
         final_ff     <= final_in;
         oidx_ff      <= oidx_in;
      end
      // working variables and schedule need no reset
      v_ff <= v_in;
      w_ff <= w_in;
   end
endmodule

### sv/sha512_stream_hasher_unit.sv
// SHA-512 stream hasher: two-entry queue front end, iterative 80-round back end.
// Full words: each is taken from the queue, then packed into the block; a full
// 128-byte block runs 80 rounds and a fold. The queue absorbs two transactions
// while the core is busy. Final word: the padded block is compressed, then the length
// block if needed; then eight digest transactions, which hold while rsp_ready is low.
// Synchronous active-high reset loads the initial hash and clears counters.
module sha512_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_message_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);
   import sha512_pkg::*;

   item_type push_d, pop_d;
   logic     pop_v, pop_r;

   assign push_d = '{word: req_message_word, nbytes: req_valid_bytes, last: req_last_word};

   sha512_queue u_queue (
      .clock, .reset, .push_valid(req_valid), .push_ready(req_ready), .push_data(push_d),
      .pop_valid(pop_v), .pop_ready(pop_r), .pop_data(pop_d));

   sha512_core u_core (
      .clock, .reset, .in_valid(pop_v), .in_ready(pop_r), .in_data(pop_d),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_word(rsp_digest_word),
      .out_index(rsp_digest_index), .out_last(rsp_digest_last));
endmodule

### sv/sha512_checker.sv
// Port-level checks for the SHA-512 stream hasher; bound to the top level.
// No package dependency.
module sha512_checker (
   input logic clock, reset, rsp_valid, rsp_ready, rsp_digest_last,
   input logic [2:0] rsp_digest_index
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_digest_index == 3'd7)))
      else $error("last flag mismatch");
   a_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_digest_last) |=>
      (rsp_valid && rsp_digest_index == $past(rsp_digest_index) + 3'd1))
      else $error("digest index skipped");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_index)))
      else $error("stalled result changed");
endmodule

bind sha512_stream_hasher_unit sha512_checker u_chk (.*);
